/* rtl/core/spc_pkg.sv */
// shared types and constants of the sliding pattern correlator
package spc_pkg;

    // width of one correlation result
    localparam int CORR_BITS = 38;

    // function codes carried on the input channel
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // shift strobes handed to every cell of the chain
    typedef struct packed {
        logic tap_shift;
        logic samp_shift;
    } cell_ctrl_t;

endpackage

/* rtl/core/sliding_pattern_correlator_core.sv */
// top level of the sliding pattern correlator: cell chain and sequencer
//
//  channel | ports                                     | role
//  --------+-------------------------------------------+-------------------------------
//  input   | s_valid s_ready s_func s_value s_last     | pattern taps and trace samples
//  output  | m_valid m_ready m_correlation m_final_window | one sum of products per window
//
// a tap beat or a sample beat that closes no window leaves s_ready high
// a sample beat that closes a window holds s_ready low until the products are
// registered, the partial sum has walked the whole chain of MAX_TAPS cells
// and the output register is loaded, a load that waits while it is occupied
// the output register lets the next beat in while a result still waits
// aresetn (synchronous, active low) clears the sequencer, counters and m_valid
module sliding_pattern_correlator_core
    import spc_pkg::*;
#(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic signed [SAMPLE_BITS-1:0] s_value,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [CORR_BITS-1:0]   m_correlation,
    output logic                          m_final_window
);

    // counters that must hold MAX_TAPS itself
    localparam int TC_W = $clog2(MAX_TAPS + 1);
    localparam logic [TC_W-1:0] TAPS_FULL = TC_W'(MAX_TAPS);

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [TC_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [TC_W-1:0] tap_count_reg, tap_count_next;
    logic [TC_W-1:0] samples_seen_reg, samples_seen_next;
    logic            load_open_reg, load_open_next;
    logic            m_valid_reg, m_valid_next;
    logic            final_reg;
    logic signed [CORR_BITS-1:0] m_corr_reg;
    logic            m_final_reg;

    logic [TC_W-1:0] base_count;
    logic [TC_W-1:0] seen_inc;
    logic            out_load;
    cell_ctrl_t      cell_ctrl;

    // chain links: element k is the output of cell k
    logic signed [SAMPLE_BITS-1:0] tap_chain  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] samp_chain [MAX_TAPS];
    logic signed [CORR_BITS-1:0]   psum_chain [MAX_TAPS];
    logic [MAX_TAPS-1:0]           cell_active;

    // taps and samples both shift in at cell 0, so cell k holds the k-th newest
    // tap next to the k-th newest sample and the pairing never depends on the
    // pattern length; cells at or beyond the tap count are masked off
    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++) begin : g_cell
            assign cell_active[k] = (TC_W'(k) < tap_count_reg);
            if (k == 0) begin : g_head
                spc_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS)
                ) u_cell (
                    .aclk     (aclk),
                    .ctrl     (cell_ctrl),
                    .active   (cell_active[k]),
                    .tap_in   (s_value),
                    .samp_in  (s_value),
                    .psum_in  ('0),
                    .tap_out  (tap_chain[k]),
                    .samp_out (samp_chain[k]),
                    .psum_out (psum_chain[k])
                );
            end else begin : g_body
                spc_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS)
                ) u_cell (
                    .aclk     (aclk),
                    .ctrl     (cell_ctrl),
                    .active   (cell_active[k]),
                    .tap_in   (tap_chain[k-1]),
                    .samp_in  (samp_chain[k-1]),
                    .psum_in  (psum_chain[k-1]),
                    .tap_out  (tap_chain[k]),
                    .samp_out (samp_chain[k]),
                    .psum_out (psum_chain[k])
                );
            end
        end
    endgenerate

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next        = state_reg;
        sweep_cnt_next    = sweep_cnt_reg;
        tap_count_next    = tap_count_reg;
        samples_seen_next = samples_seen_reg;
        load_open_next    = load_open_reg;
        m_valid_next      = m_valid_reg;
        out_load          = 1'b0;
        cell_ctrl         = '0;

        // a closed pattern restarts at the next tap beat
        base_count = load_open_reg ? tap_count_reg : '0;
        // samples seen in this trace, saturating at the chain length
        seen_inc = (samples_seen_reg < TAPS_FULL) ? samples_seen_reg + 1'b1
                                                  : samples_seen_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == FUNC_LOAD) begin
                        load_open_next    = !s_last;
                        // a pattern restart also restarts the trace
                        samples_seen_next = load_open_reg ? samples_seen_reg : '0;
                        // taps beyond the chain length are dropped
                        if (base_count < TAPS_FULL) begin
                            tap_count_next      = base_count + 1'b1;
                            cell_ctrl.tap_shift = 1'b1;
                        end else begin
                            tap_count_next = base_count;
                        end
                    end else begin
                        cell_ctrl.samp_shift = 1'b1;
                        samples_seen_next    = s_last ? '0 : seen_inc;
                        // window full: run the partial sum down the chain
                        if (seen_inc >= tap_count_reg) begin
                            state_next     = ST_SWEEP;
                            sweep_cnt_next = '0;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                // products are registered after the shift, then the sum walks
                // down the chain from cell register to cell register
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == TAPS_FULL) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait only while the output register is still occupied
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            sweep_cnt_reg    <= '0;
            tap_count_reg    <= '0;
            samples_seen_reg <= '0;
            load_open_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            sweep_cnt_reg    <= sweep_cnt_next;
            tap_count_reg    <= tap_count_next;
            samples_seen_reg <= samples_seen_next;
            load_open_reg    <= load_open_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // result payload: final flag caught with the sample, sum taken at the chain end
    always_ff @(posedge aclk) begin
        if (cell_ctrl.samp_shift) begin
            final_reg <= s_last;
        end
        if (out_load) begin
            m_corr_reg  <= psum_chain[MAX_TAPS-1];
            m_final_reg <= final_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_correlation  = m_corr_reg;
    assign m_final_window = m_final_reg;

    // a new result only ever comes out of the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the done state");

    // the tap mask must not move while a sum walks the chain
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |=> $stable(tap_count_reg))
        else $error("tap count changed during a sweep");

    // counters stay within the chain length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tap_count_reg <= TAPS_FULL) && (samples_seen_reg <= TAPS_FULL))
        else $error("tap or sample counter beyond chain length");

    // the sweep does not end before the count reaches the chain length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) && (sweep_cnt_reg != TAPS_FULL) |=>
            (state_reg == ST_SWEEP))
        else $error("sweep left early");

endmodule

/* rtl/core/spc_cell.sv */
// one correlator cell: pattern tap, window sample, product and partial sum
module spc_cell
    import spc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  cell_ctrl_t                    ctrl,
    input  logic                          active,
    input  logic signed [SAMPLE_BITS-1:0] tap_in,
    input  logic signed [SAMPLE_BITS-1:0] samp_in,
    input  logic signed [CORR_BITS-1:0]   psum_in,
    output logic signed [SAMPLE_BITS-1:0] tap_out,
    output logic signed [SAMPLE_BITS-1:0] samp_out,
    output logic signed [CORR_BITS-1:0]   psum_out
);

    localparam int PROD_BITS = 2 * SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] tap_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [CORR_BITS-1:0]   psum_reg;
    logic signed [CORR_BITS-1:0]   addend;

    // inactive cells add nothing, whatever they hold
    assign addend = active ? CORR_BITS'(prod_reg) : '0;

    always_ff @(posedge aclk) begin
        if (ctrl.tap_shift) begin
            tap_reg <= tap_in;
        end
        if (ctrl.samp_shift) begin
            samp_reg <= samp_in;
        end
        prod_reg <= PROD_BITS'(samp_reg) * PROD_BITS'(tap_reg);
        psum_reg <= psum_in + addend;
    end

    assign tap_out  = tap_reg;
    assign samp_out = samp_reg;
    assign psum_out = psum_reg;

endmodule
